FILE: rtl/lpmd_pkg.sv
// Package for the length-prefixed message deframer.
// Parse phase encoding, result beat layout and field widths.
// No dependencies.
`timescale 1ns / 1ps

package lpmd_pkg;

    // Fixed field widths
    localparam int unsigned ID_W      = 14;
    localparam int unsigned LEN_W     = 24;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned M_DATA_W  = 48;   // 14 + 24 + 8 = 46, padded to 6 bytes
    localparam int unsigned M_USER_W  = 2;

    // Reset value of the maximum payload register
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 24'd8192;

    // Where the parser is within a frame
    typedef enum logic [1:0] {
        PH_HDR_HI = 2'd0,   // awaiting high header byte
        PH_HDR_LO = 2'd1,   // awaiting low header byte
        PH_LEN    = 2'd2,   // taking big-endian length bytes
        PH_PAY    = 2'd3    // passing payload bytes
    } phase_t;

    // One result beat
    typedef struct packed {
        logic [ID_W-1:0]   message_id;
        logic [LEN_W-1:0]  message_length;
        logic [BYTE_W-1:0] payload_byte;
        logic              is_last;
        logic              is_empty;
        logic              oversize;
    } result_t;

endpackage

FILE: rtl/length_prefixed_message_deframer_core.sv
// Length-prefixed message deframer, top level.
// Input byte register, frame parser and result register.
// Depends on lpmd_pkg and lpmd_parser.
`timescale 1ns / 1ps

// Usage:
//   s_axis_* carries the received byte stream, one byte per beat. Each frame
//   is a 16-bit big-endian header (14-bit id, 2-bit length-byte count), 0 to 3
//   big-endian length bytes, then the payload.
//   m_axis_* gives one beat per payload byte, tagged with id and length;
//   tlast marks the final byte of a message. A zero-length message gives a
//   single beat with the empty flag and tlast set. Header and length bytes
//   give no beat.
//   cfg_wr_en/cfg_wr_data write the maximum payload length; longer messages
//   pass through with the oversize flag on every beat. Write it only while
//   the block is idle.
//   An accepted byte waits in the input register, is parsed from there and
//   its beat is stored in the result register, which drives m_axis.
//   Throughput: one byte per cycle, unless m_axis_tready is low with a beat held.
//   Reset (aresetn low, synchronous) empties both registers, sets the parser
//   to await a header and restores the maximum to 8192.
//   When m_axis_tready is low with a beat held, the held input byte waits and
//   s_axis_tready drops; nothing is lost or repeated.
module length_prefixed_message_deframer_core import lpmd_pkg::*; #(
    parameter int unsigned LENGTH_BITS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration
    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data,     // max_payload
    // Byte stream in
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [BYTE_W-1:0]   s_axis_tdata,    // [7:0] rx_byte
    // Result beats out
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,    // [13:0] message_id, [37:14] message_length,
                                                 // [45:38] payload_byte, [47:46] zero
    output logic                m_axis_tlast,    // is_last
    output logic [M_USER_W-1:0] m_axis_tuser     // [0] is_empty, [1] oversize
);

    logic [LEN_W-1:0]  max_payload_reg;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    logic              advance;
    logic              res_valid;
    result_t           res;

    // Parse the held byte when the result register can take its beat
    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;

    assign in_valid_next  = (s_axis_tvalid & s_axis_tready) | (in_valid_reg & ~advance);
    assign out_valid_next = res_valid | (out_valid_reg & ~m_axis_tready);

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RST;
        end else if (cfg_wr_en) begin
            max_payload_reg <= cfg_wr_data;
        end
    end

    // Input byte register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    lpmd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .rx_byte     (in_byte_reg),
        .max_payload (max_payload_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.payload_byte, out_reg.message_length,
                            out_reg.message_id};
    assign m_axis_tlast  = out_reg.is_last;
    assign m_axis_tuser  = {out_reg.oversize, out_reg.is_empty};

endmodule

FILE: rtl/lpmd_parser.sv
// Frame parser of the length-prefixed message deframer.
// Holds the per-frame state and turns one byte into at most one result.
// Depends on lpmd_pkg.
`timescale 1ns / 1ps

module lpmd_parser import lpmd_pkg::*; #(
    parameter int unsigned LENGTH_BITS = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,      // process rx_byte this cycle
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [LEN_W-1:0]  max_payload,
    output logic              res_valid,
    output result_t           res
);

    phase_t                 phase_reg, phase_next;
    logic [BYTE_W-1:0]      hdr_hi_reg, hdr_hi_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [1:0]             lbl_reg, lbl_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [LEN_W-1:0]       len_ext;
    logic                   emit;
    logic                   emit_last;
    logic                   emit_empty;
    logic [BYTE_W-1:0]      emit_byte;
    logic [1:0]             lbl_dec;
    logic [LENGTH_BITS-1:0] acc_shift;

    assign lbl_dec   = lbl_reg - 2'd1;
    assign acc_shift = {acc_reg[LENGTH_BITS-BYTE_W-1:0], rx_byte};

    // Next state
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HDR_HI: phase_next = PH_HDR_LO;
            PH_HDR_LO: phase_next = (rx_byte[1:0] == 2'd0) ? PH_HDR_HI : PH_LEN;
            PH_LEN: begin
                if (lbl_dec == 2'd0) begin
                    phase_next = (acc_shift == '0) ? PH_HDR_HI : PH_PAY;
                end
            end
            PH_PAY: begin
                if (left_reg <= LENGTH_BITS'(1)) phase_next = PH_HDR_HI;
            end
            default: phase_next = PH_HDR_HI;
        endcase
    end

    // Datapath updates and result decode
    always_comb begin
        hdr_hi_next = hdr_hi_reg;
        id_next     = id_reg;
        lbl_next    = lbl_reg;
        acc_next    = acc_reg;
        left_next   = left_reg;
        emit        = 1'b0;
        emit_last   = 1'b0;
        emit_empty  = 1'b0;
        emit_byte   = '0;
        unique case (phase_reg)
            PH_HDR_HI: hdr_hi_next = rx_byte;
            PH_HDR_LO: begin
                id_next   = {hdr_hi_reg, rx_byte[7:2]};
                lbl_next  = rx_byte[1:0];
                acc_next  = '0;
                left_next = '0;
                if (rx_byte[1:0] == 2'd0) begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_empty = 1'b1;
                end
            end
            PH_LEN: begin
                acc_next = acc_shift;
                lbl_next = lbl_dec;
                if (lbl_dec == 2'd0) begin
                    if (acc_shift == '0) begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        emit_empty = 1'b1;
                    end else begin
                        left_next = acc_shift;
                    end
                end
            end
            PH_PAY: begin
                emit      = 1'b1;
                emit_byte = rx_byte;
                if (left_reg <= LENGTH_BITS'(1)) begin
                    emit_last = 1'b1;
                    left_next = '0;
                end else begin
                    left_next = left_reg - LENGTH_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    // Length widened to the port width
    always_comb begin
        len_ext                  = '0;
        len_ext[LENGTH_BITS-1:0] = acc_next;
    end

    assign res_valid          = step_en & emit;
    assign res.message_id     = id_next;
    assign res.message_length = len_ext;
    assign res.payload_byte   = emit_byte;
    assign res.is_last        = emit_last;
    assign res.is_empty       = emit_empty;
    assign res.oversize       = (len_ext > max_payload);

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR_HI;
            hdr_hi_reg <= '0;
            id_reg     <= '0;
            lbl_reg    <= '0;
            acc_reg    <= '0;
            left_reg   <= '0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            hdr_hi_reg <= hdr_hi_next;
            id_reg     <= id_next;
            lbl_reg    <= lbl_next;
            acc_reg    <= acc_next;
            left_reg   <= left_next;
        end
    end

endmodule
